### src/pfrc_pkg.sv
// ----------------------------------------------------------------------------
// pfrc_pkg
// Shared types, constants and helpers of the prefix filter router counter.
// ----------------------------------------------------------------------------
package pfrc_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned LINK_W  = 4;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned CFG_W   = 6;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned ROUTES_DEF  = 32;
  localparam int unsigned FILTERS_DEF = 16;
  localparam int unsigned LINKS_DEF   = 16;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(32);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WR_ROUTE  = 2'd0,
    FUNC_WR_FILTER = 2'd1,
    FUNC_CLASSIFY  = 2'd2,
    FUNC_RD_COUNT  = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROUTE_COUNT  = 1'b0,
    CFG_FILTER_COUNT = 1'b1
  } cfg_idx_t;

  // Search token walking down the cell chain.
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic              hit;
    logic [LEN_W-1:0]  best_len;
    logic [LINK_W-1:0] best_link;
  } srch_t;

  // Write broadcast to the cells.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  len;
    logic [LINK_W-1:0] link;
  } cell_wr_t;

  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] l;
    l = (len > MAX_LEN) ? MAX_LEN : len;
    if (l == '0) return '0;
    return ~({ADDR_W{1'b0}} | ({ADDR_W{1'b1}} >> l));
  endfunction

endpackage

### src/pfrc_stream_if.sv
// ----------------------------------------------------------------------------
// pfrc_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface pfrc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/pfrc_cell.sv
// ----------------------------------------------------------------------------
// pfrc_cell
// One table entry: stores a prefix, compares the passing token, forwards it.
// ----------------------------------------------------------------------------
module pfrc_cell
  import pfrc_pkg::*;
#(
  parameter bit IS_ROUTE = 1'b1
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cell_wr_t wr,
  input  logic     in_use,
  input  srch_t    s_in,
  output srch_t    s_out
);
  logic [ADDR_W-1:0] prefix_r;
  logic [LEN_W-1:0]  len_r;
  logic [LINK_W-1:0] link_r;
  logic [LEN_W-1:0]  len_c;
  logic [ADDR_W-1:0] mask;
  logic              hits;
  srch_t             s_nxt;
  srch_t             s_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      prefix_r <= wr.prefix;
      len_r    <= wr.len;
      link_r   <= wr.link;
    end
  end

  assign len_c = (len_r > MAX_LEN) ? MAX_LEN : len_r;
  assign mask  = prefix_mask(len_r);
  assign hits  = in_use && ((s_in.addr & mask) == (prefix_r & mask));

  always_comb begin
    s_nxt = s_in;
    if (IS_ROUTE) begin
      if (hits && (!s_in.hit || len_c > s_in.best_len)) begin
        s_nxt.hit       = 1'b1;
        s_nxt.best_len  = len_c;
        s_nxt.best_link = link_r;
      end
    end else if (hits) begin
      s_nxt.hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.valid <= 1'b0;
    end else begin
      s_r.valid <= s_in.valid;
    end
    s_r.addr      <= s_nxt.addr;
    s_r.hit       <= s_nxt.hit;
    s_r.best_len  <= s_nxt.best_len;
    s_r.best_link <= s_nxt.best_link;
  end

  assign s_out = s_r;
endmodule

### src/pfrc_chain.sv
// ----------------------------------------------------------------------------
// pfrc_chain
// Row of cells; the search token advances one cell per cycle.
// ----------------------------------------------------------------------------
module pfrc_chain
  import pfrc_pkg::*;
#(
  parameter int unsigned N        = 32,
  parameter bit          IS_ROUTE = 1'b1,
  parameter int unsigned NW       = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [ADDR_W-1:0] wr_prefix,
  input  logic [LEN_W-1:0]  wr_len,
  input  logic [LINK_W-1:0] wr_link,
  input  logic [NW-1:0] count,
  input  srch_t         s_in,
  output srch_t         s_out
);
  srch_t    tap [N+1];
  cell_wr_t wr  [N];

  assign tap[0] = s_in;

  for (genvar i = 0; i < N; i++) begin : g_cell
    always_comb begin
      wr[i].en     = wr_en && (32'(wr_idx) == i);
      wr[i].prefix = wr_prefix;
      wr[i].len    = wr_len;
      wr[i].link   = wr_link;
    end
    pfrc_cell #(.IS_ROUTE(IS_ROUTE)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .wr     (wr[i]),
      .in_use (32'(count) > i),
      .s_in   (tap[i]),
      .s_out  (tap[i+1])
    );
  end

  assign s_out = tap[N];
endmodule

### src/prefix_filter_router_counter_core.sv
// ----------------------------------------------------------------------------
// prefix_filter_router_counter_core
// Filter reject, longest-prefix route lookup and per-link packet counters.
// ----------------------------------------------------------------------------
// A classify transaction walks the filter cells, then the route cells, one
// cell per cycle, and then updates the link counter. Only one transaction is
// in flight at a time, so a new request is accepted only after the previous
// result has been taken. Writes and counter reads present their result in
// the cycle after acceptance. Results sit in an output register. in_ready
// goes high again in the cycle after that result is taken.
module prefix_filter_router_counter_core
  import pfrc_pkg::*;
#(
  parameter int unsigned ROUTES  = ROUTES_DEF,
  parameter int unsigned FILTERS = FILTERS_DEF,
  parameter int unsigned LINKS   = LINKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [IDX_W-1:0]      in_entry_index,
  input  logic [ADDR_W-1:0]     in_address,
  input  logic [LEN_W-1:0]      in_prefix_len,
  input  logic [LINK_W-1:0]     in_link,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [LINK_W-1:0]     out_out_link,
  output logic                  out_rejected,
  output logic                  out_matched,
  output logic [CNT_W-1:0]      out_count_value
);
  localparam int unsigned CW = (LINKS > 1) ? $clog2(LINKS) : 1;

  typedef enum logic [1:0] {S_IDLE, S_BUSY, S_CNT, S_OUT} state_t;

  state_t            state_r;
  logic [CFG_W-1:0]  route_cnt_r;
  logic [IDX_W-1:0]  filt_cnt_r;
  logic [CNT_W-1:0]  cnt_r [LINKS];

  logic [LINK_W-1:0] o_link_r;
  logic              o_rej_r, o_match_r;
  logic [CNT_W-1:0]  o_cnt_r;

  srch_t f_in, f_out, r_in, r_out;
  logic  acc;
  logic  rej_r;

  assign acc      = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      route_cnt_r <= '0;
      filt_cnt_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_ROUTE_COUNT:  route_cnt_r <= cfg_wdata;
        CFG_FILTER_COUNT: filt_cnt_r  <= cfg_wdata[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    f_in           = '0;
    f_in.valid     = acc && (func_t'(in_func) == FUNC_CLASSIFY);
    f_in.addr      = in_address;
  end

  pfrc_chain #(.N(FILTERS), .IS_ROUTE(1'b0), .NW(IDX_W)) u_filt (
    .clk (clk), .rst_n (rst_n),
    .wr_en (acc && func_t'(in_func) == FUNC_WR_FILTER),
    .wr_idx (in_entry_index), .wr_prefix (in_address),
    .wr_len (in_prefix_len), .wr_link (in_link),
    .count (filt_cnt_r), .s_in (f_in), .s_out (f_out)
  );

  always_comb begin
    r_in       = '0;
    r_in.valid = f_out.valid;
    r_in.addr  = f_out.addr;
  end

  always_ff @(posedge clk) begin
    if (f_out.valid) rej_r <= f_out.hit;
  end

  pfrc_chain #(.N(ROUTES), .IS_ROUTE(1'b1), .NW(CFG_W)) u_route (
    .clk (clk), .rst_n (rst_n),
    .wr_en (acc && func_t'(in_func) == FUNC_WR_ROUTE),
    .wr_idx (in_entry_index), .wr_prefix (in_address),
    .wr_len (in_prefix_len), .wr_link (in_link),
    .count (route_cnt_r), .s_in (r_in), .s_out (r_out)
  );

  logic [LINK_W-1:0] res_link;
  logic              res_match;
  logic [CNT_W-1:0]  sel_cnt;
  assign res_match = !rej_r && r_out.hit;
  assign res_link  = res_match ? r_out.best_link : '0;
  assign sel_cnt   = cnt_r[CW'(res_link)];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < LINKS; i++) cnt_r[i] <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            o_link_r  <= '0;
            o_rej_r   <= 1'b0;
            o_match_r <= 1'b0;
            o_cnt_r   <= '0;
            priority case (func_t'(in_func))
              FUNC_CLASSIFY: state_r <= S_BUSY;
              FUNC_RD_COUNT: begin
                if (32'(in_entry_index) < LINKS) o_cnt_r <= cnt_r[CW'(in_entry_index)];
                state_r <= S_OUT;
              end
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_BUSY: begin
          if (r_out.valid) begin
            o_link_r  <= res_link;
            o_rej_r   <= rej_r;
            o_match_r <= res_match;
            if (32'(res_link) < LINKS) begin
              cnt_r[CW'(res_link)] <= sel_cnt + CNT_W'(1);
              o_cnt_r <= sel_cnt + CNT_W'(1);
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = (state_r == S_OUT);
  assign out_out_link    = o_link_r;
  assign out_rejected    = o_rej_r;
  assign out_matched     = o_match_r;
  assign out_count_value = o_cnt_r;

  a_one_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("overlap");
  a_rej_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_rejected && out_matched)) else $error("rej and match");
  a_rej_link0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> out_out_link == '0) else $error("rej link");
endmodule

### tb/tb_prefix_filter_router_counter_core.sv
// ----------------------------------------------------------------------------
// tb_prefix_filter_router_counter_core
// Self-checking bench for the prefix filter router counter core. It loads
// the route and filter tables and then runs phases of random writes,
// classifies and counter reads over several table-size settings and several
// idle/stall patterns. A predictor keeps its own tables and link counters.
// Every result transaction is checked field by field against the oldest
// expected result.
// ----------------------------------------------------------------------------
module tb_prefix_filter_router_counter_core;
  import pfrc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NROUTE = 32;
  localparam int NFILT  = 16;
  localparam int NLINK  = 16;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    func_t              func;
    logic [IDX_W-1:0]   idx;
    logic [ADDR_W-1:0]  addr;
    logic [LEN_W-1:0]   plen;
    logic [LINK_W-1:0]  link;
  } pkt_req_t;

  typedef struct packed {
    logic [LINK_W-1:0]  link;
    logic               rej;
    logic               hit;
    logic [CNT_W-1:0]   count;
  } pkt_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  pfrc_stream_if #(.T(pkt_req_t)) in_if ();
  pfrc_stream_if #(.T(pkt_res_t)) out_if ();

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  prefix_filter_router_counter_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_if.valid),
    .in_ready        (in_if.ready),
    .in_func         (in_if.data.func),
    .in_entry_index  (in_if.data.idx),
    .in_address      (in_if.data.addr),
    .in_prefix_len   (in_if.data.plen),
    .in_link         (in_if.data.link),
    .out_valid       (out_if.valid),
    .out_ready       (out_if.ready),
    .out_out_link    (out_if.data.link),
    .out_rejected    (out_if.data.rej),
    .out_matched     (out_if.data.hit),
    .out_count_value (out_if.data.count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [ADDR_W-1:0] rt_prefix [NROUTE];
  logic [LEN_W-1:0]  rt_len    [NROUTE];
  logic [LINK_W-1:0] rt_link   [NROUTE];
  logic [ADDR_W-1:0] ft_prefix [NFILT];
  logic [LEN_W-1:0]  ft_len    [NFILT];
  logic [CNT_W-1:0]  link_cnt  [NLINK];
  int unsigned route_cnt_cfg = 0;
  int unsigned filt_cnt_cfg  = 0;

  pkt_req_t pending_pkts[$];
  pkt_res_t expected_res[$];
  logic [ADDR_W-1:0] addr_pool[8];

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  recv_hold = 1'b0;
  bit  in_taken = 1'b0;
  int  errors = 0;
  int  n_class = 0, n_rej = 0, n_hit = 0, n_read = 0, n_wr = 0;
  longint cycles = 0;

  function automatic logic [ADDR_W-1:0] len_mask(int unsigned l);
    if (l == 0) return '0;
    if (l >= 32) return '1;
    return ~(32'hFFFF_FFFF >> l);
  endfunction

  function automatic bit addr_hits(logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] p,
                                   int unsigned l);
    logic [ADDR_W-1:0] m;
    m = len_mask(l);
    return (a & m) == (p & m);
  endfunction

  task automatic lookup_and_count(input pkt_req_t r);
    pkt_res_t res;
    int unsigned nf, nr, l, best_l;
    bit found;
    res = '0;
    case (r.func)
      FUNC_WR_ROUTE: begin
        rt_prefix[r.idx] = r.addr;
        rt_len[r.idx] = r.plen;
        rt_link[r.idx] = r.link;
      end
      FUNC_WR_FILTER: begin
        if (r.idx < NFILT) begin
          ft_prefix[r.idx[3:0]] = r.addr;
          ft_len[r.idx[3:0]] = r.plen;
        end
      end
      FUNC_CLASSIFY: begin
        nf = (filt_cnt_cfg < NFILT) ? filt_cnt_cfg : NFILT;
        nr = (route_cnt_cfg < NROUTE) ? route_cnt_cfg : NROUTE;
        for (int k = 0; k < nf; k++)
          if (!res.rej && addr_hits(r.addr, ft_prefix[k], ft_len[k])) res.rej = 1'b1;
        if (!res.rej) begin
          found = 1'b0;
          best_l = 0;
          for (int k = 0; k < nr; k++) begin
            l = (rt_len[k] > 32) ? 32 : rt_len[k];
            if (addr_hits(r.addr, rt_prefix[k], l) && (!found || l > best_l)) begin
              found = 1'b1;
              best_l = l;
              res.link = rt_link[k];
            end
          end
          res.hit = found;
        end
        link_cnt[res.link] = link_cnt[res.link] + 1;
        res.count = link_cnt[res.link];
        n_class++;
        if (res.rej) n_rej++;
        if (res.hit) n_hit++;
      end
      default: begin
        if (r.idx < NLINK) res.count = link_cnt[r.idx[3:0]];
        n_read++;
      end
    endcase
    if (r.func inside {FUNC_WR_ROUTE, FUNC_WR_FILTER}) n_wr++;
    expected_res.push_back(res);
  endtask

  task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
                                 input logic [CNT_W-1:0] want);
    errors++;
    $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
  endtask

  // driver
  always @(negedge clk) begin
    pkt_req_t nxt;
    logic     v;
    v = in_if.valid;
    nxt = in_if.data;
    if (rst_n && (!in_if.valid || in_taken)) begin
      if (in_taken) void'(pending_pkts.pop_front());
      in_taken = 1'b0;
      v = 1'b0;
      if (pending_pkts.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        v = 1'b1;
        nxt = pending_pkts[0];
      end
    end
    in_if.valid <= v;
    in_if.data <= nxt;
    out_if.ready <= rst_n && !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // predictor on accepted input
  always @(posedge clk)
    if (rst_n && in_if.valid && in_if.ready) begin
      lookup_and_count(in_if.data);
      in_taken = 1'b1;
    end

  // result monitor
  always @(posedge clk) begin
    pkt_res_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_res.size() == 0) begin
        report_mismatch("unexpected result", out_if.data.count, '0);
      end else begin
        w = expected_res.pop_front();
        if (out_if.data.link !== w.link) report_mismatch("out_link", out_if.data.link, w.link);
        if (out_if.data.rej !== w.rej) report_mismatch("rejected", out_if.data.rej, w.rej);
        if (out_if.data.hit !== w.hit) report_mismatch("matched", out_if.data.hit, w.hit);
        if (out_if.data.count !== w.count)
          report_mismatch("count_value", out_if.data.count, w.count);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic wait_drained();
    wait (pending_pkts.size() == 0 && !in_if.valid && expected_res.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_idx_t idx, input int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= CFG_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ROUTE_COUNT) route_cnt_cfg = val;
    else filt_cnt_cfg = val;
  endtask

  function automatic pkt_req_t make_pkt(func_t f, int unsigned idx, logic [31:0] a,
                                        int unsigned pl, int unsigned lk);
    pkt_req_t p;
    p.func = f;
    p.idx = IDX_W'(idx);
    p.addr = a;
    p.plen = LEN_W'(pl);
    p.link = LINK_W'(lk);
    return p;
  endfunction

  function automatic logic [31:0] near_addr();
    return addr_pool[$urandom_range(7)] ^ (32'($urandom) & ~len_mask($urandom_range(8, 32)));
  endfunction

  function automatic pkt_req_t random_pkt();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 15)
      return make_pkt(FUNC_WR_ROUTE, $urandom_range(31), near_addr(),
                      ($urandom_range(9) == 0) ? $urandom_range(33, 63) : $urandom_range(0, 32),
                      $urandom_range(15));
    if (sel < 25)
      return make_pkt(FUNC_WR_FILTER, $urandom_range(31),
                      ($urandom_range(3) == 0) ? near_addr() : 32'($urandom),
                      ($urandom_range(19) == 0) ? $urandom_range(63) : $urandom_range(20, 40),
                      $urandom_range(15));
    if (sel < 80)
      return make_pkt(FUNC_CLASSIFY, $urandom_range(31),
                      ($urandom_range(7) == 0) ? 32'($urandom) : near_addr(),
                      $urandom_range(63), $urandom_range(15));
    return make_pkt(FUNC_RD_COUNT, $urandom_range(31), $urandom, $urandom_range(63),
                    $urandom_range(15));
  endfunction

  task automatic run_phase(int unsigned rc, int unsigned fc, int snd, int rcv, int n);
    wait_drained();
    write_cfg(CFG_ROUTE_COUNT, rc);
    write_cfg(CFG_FILTER_COUNT, fc);
    send_idle_pct = snd;
    recv_stall_pct = rcv;
    for (int i = 0; i < n; i++) pending_pkts.push_back(random_pkt());
    wait (pending_pkts.size() == 0);
  endtask

  initial begin
    for (int i = 0; i < NLINK; i++) link_cnt[i] = '0;
    for (int i = 0; i < 8; i++) addr_pool[i] = $urandom;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fill both tables so that every entry is defined
    for (int i = 0; i < NROUTE; i++)
      pending_pkts.push_back(make_pkt(FUNC_WR_ROUTE, i, near_addr(), $urandom_range(8, 32),
                                      $urandom_range(15)));
    for (int i = 0; i < NFILT; i++)
      pending_pkts.push_back(make_pkt(FUNC_WR_FILTER, i, $urandom, $urandom_range(24, 32), 0));
    pending_pkts.push_back(make_pkt(FUNC_CLASSIFY, 0, addr_pool[0], 0, 0));
    wait_drained();

    // directed: zero length default, long length, ties, reject, reads
    write_cfg(CFG_ROUTE_COUNT, 4);
    write_cfg(CFG_FILTER_COUNT, 1);
    pending_pkts.push_back(make_pkt(FUNC_WR_ROUTE, 0, 32'hFFFF_FFFF, 0, 15));
    pending_pkts.push_back(make_pkt(FUNC_WR_ROUTE, 1, 32'hC0A8_0100, 24, 5));
    pending_pkts.push_back(make_pkt(FUNC_WR_ROUTE, 2, 32'hC0A8_01FF, 24, 9));
    pending_pkts.push_back(make_pkt(FUNC_WR_ROUTE, 3, 32'hC0A8_0107, 63, 12));
    pending_pkts.push_back(make_pkt(FUNC_WR_FILTER, 0, 32'h0A00_0000, 8, 0));
    pending_pkts.push_back(make_pkt(FUNC_WR_FILTER, 31, 32'h0, 0, 0));
    pending_pkts.push_back(make_pkt(FUNC_CLASSIFY, 0, 32'hC0A8_0107, 63, 15));
    pending_pkts.push_back(make_pkt(FUNC_CLASSIFY, 0, 32'hC0A8_0142, 0, 0));
    pending_pkts.push_back(make_pkt(FUNC_CLASSIFY, 0, 32'h0000_0000, 0, 0));
    pending_pkts.push_back(make_pkt(FUNC_CLASSIFY, 31, 32'h0AFF_FFFF, 0, 0));
    pending_pkts.push_back(make_pkt(FUNC_WR_FILTER, 1, 32'h1234_5678, 0, 0));
    pending_pkts.push_back(make_pkt(FUNC_RD_COUNT, 0, 0, 0, 0));
    pending_pkts.push_back(make_pkt(FUNC_RD_COUNT, 12, 32'hFFFF_FFFF, 63, 15));
    pending_pkts.push_back(make_pkt(FUNC_RD_COUNT, 31, 0, 0, 0));
    wait_drained();
    write_cfg(CFG_FILTER_COUNT, 2);
    pending_pkts.push_back(make_pkt(FUNC_CLASSIFY, 0, 32'hC0A8_0107, 0, 0));
    pending_pkts.push_back(make_pkt(FUNC_RD_COUNT, 0, 0, 0, 0));
    pending_pkts.push_back(make_pkt(FUNC_WR_FILTER, 1, 32'h5555_0000, 32, 0));

    run_phase(32, 16, 0, 0, 240);
    run_phase(5, 0, 58, 0, 240);
    fork
      run_phase(32, 4, 0, 0, 240);
      begin
        repeat (100) @(posedge clk);
        recv_hold = 1'b1;
        repeat (600) @(posedge clk);
        recv_hold = 1'b0;
      end
    join
    run_phase(0, 16, 0, 58, 240);
    run_phase(63, 31, 6, 6, 240);
    run_phase(17, 1, 58, 58, 250);
    wait_drained();

    $display("%0d classifies (%0d rejected, %0d routed), %0d counter reads, %0d writes",
             n_class, n_rej, n_hit, n_read, n_wr);
    $display("route/filter counts swept from 0 to over-size; %0d mismatches", errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
src/pfrc_pkg.sv
src/pfrc_stream_if.sv
src/pfrc_cell.sv
src/pfrc_chain.sv
src/prefix_filter_router_counter_core.sv
tb/tb_prefix_filter_router_counter_core.sv
